### design/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg: shared definitions for the axis-angle vector rotation block
// Formats, widths, the CORDIC arctangent table and the item passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // Component and angle formats
  localparam int COMP_W     = 32;
  localparam int ANGLE_W    = 16;
  localparam int TURN_W     = 32;
  localparam int UNIT_SHIFT = 30;

  // Normalised axis magnitudes, square root and quotient widths
  localparam int NMAG_W = UNIT_SHIFT;
  localparam int SQ_W   = 2 * NMAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int REM_W  = 64;
  localparam int ROOT_W = SUM_W / 2;
  localparam int Q_W    = UNIT_SHIFT + 1;
  localparam int U_W    = UNIT_SHIFT + 2;

  // CORDIC datapath
  localparam int CS_W = UNIT_SHIFT + 4;
  localparam int Z_W  = UNIT_SHIFT + 2;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
  localparam int DEF_CORDIC_STAGES = 16;

  // Rounded intermediate terms and the wide rounding input
  localparam int R_W   = 35;
  localparam int RND_W = 72;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 4;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [UNIT_SHIFT-1:0] ATAN_TURN [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // Item handed from the front end through the queue
  typedef struct packed {
    logic [2:0][COMP_W-1:0] vec;
    logic [2:0]             neg;
    logic [2:0][NMAG_W-1:0] nmag;
    logic [ANGLE_W-1:0]     angle;
    logic                   zero;
  } aavr_item_t;

  // Round half up from Q2.30 scaling: add one half, then shift with floor.
  function automatic logic signed [R_W-1:0] rnd30(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] t;
    t = (v + (RND_W'(1) <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
    return t[R_W-1:0];
  endfunction

endpackage

### design/aavr_front.sv
// ----------------------------------------------------------------------------
// aavr_front: input stage of the rotation block
// Accepts transactions, takes axis magnitudes, flags a zero axis and scales
// the axis so that its largest magnitude lies in [2^29, 2^30).
// ----------------------------------------------------------------------------
module aavr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [207:0]           s_tdata,
  output logic                   q_valid,
  input  logic                   q_ready,
  output aavr_pkg::aavr_item_t   q_item
);

  localparam int LEN_W  = $clog2(aavr_pkg::COMP_W + 1);
  localparam int WIDE_W = aavr_pkg::COMP_W + aavr_pkg::UNIT_SHIFT;

  logic                                  s1_v;
  logic [2:0][aavr_pkg::COMP_W-1:0]      s1_vec;
  logic [2:0]                            s1_neg;
  logic [2:0][aavr_pkg::COMP_W-1:0]      s1_mag;
  logic [aavr_pkg::ANGLE_W-1:0]          s1_angle;
  logic                                  s1_zero;
  logic                                  s2_v;
  aavr_pkg::aavr_item_t                  s2_item;
  aavr_pkg::aavr_item_t                  item_next;
  logic                                  s1_move;
  logic                                  s2_move;
  logic [aavr_pkg::COMP_W-1:0]           or_mag;
  logic [LEN_W-1:0]                      len;
  logic [WIDE_W-1:0]                     wide [3];
  logic [2:0][aavr_pkg::COMP_W-1:0]      ax;

  // Stage movement: each stage moves when the next one has room.
  always_comb begin
    s2_move  = !s2_v || q_ready;
    s1_move  = !s1_v || s2_move;
    s_tready = s1_move;
  end

  // Unpack the axis from the transaction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = s_tdata[(3 + i) * aavr_pkg::COMP_W +: aavr_pkg::COMP_W];
    end
  end

  // Bit length of the largest magnitude equals that of their OR; scale by it.
  always_comb begin
    or_mag = s1_mag[0] | s1_mag[1] | s1_mag[2];
    len    = '0;
    for (int b = 0; b < aavr_pkg::COMP_W; b++) begin
      if (or_mag[b]) len = LEN_W'(b + 1);
    end
    item_next.vec   = s1_vec;
    item_next.neg   = s1_neg;
    item_next.angle = s1_angle;
    item_next.zero  = s1_zero;
    for (int i = 0; i < 3; i++) begin
      wide[i] = {s1_mag[i], {aavr_pkg::UNIT_SHIFT{1'b0}}} >> len;
      item_next.nmag[i] = wide[i][aavr_pkg::NMAG_W-1:0];
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_move) s1_v <= s_tvalid;
      if (s2_move) s2_v <= s1_v;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_move && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        s1_vec[i] <= s_tdata[i * aavr_pkg::COMP_W +: aavr_pkg::COMP_W];
        s1_neg[i] <= ax[i][aavr_pkg::COMP_W-1];
        s1_mag[i] <= ax[i][aavr_pkg::COMP_W-1] ? (~ax[i] + 1'b1) : ax[i];
      end
      s1_angle <= s_tdata[6 * aavr_pkg::COMP_W +: aavr_pkg::ANGLE_W];
      s1_zero  <= (ax[0] == '0) && (ax[1] == '0) && (ax[2] == '0);
    end
    if (s2_move && s1_v) begin
      s2_item <= item_next;
    end
  end

  assign q_valid = s2_v;
  assign q_item  = s2_item;

endmodule

### design/aavr_queue.sv
// ----------------------------------------------------------------------------
// aavr_queue: short queue between the front and back ends
// Holds classified items so that either side may stall on its own.
// ----------------------------------------------------------------------------
module aavr_queue #(
  parameter int DEPTH = aavr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  aavr_pkg::aavr_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output aavr_pkg::aavr_item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  aavr_pkg::aavr_item_t mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 push;
  logic                 pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  // A lone push raises the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

### design/aavr_back.sv
// ----------------------------------------------------------------------------
// aavr_back: arithmetic pipeline of the rotation block
// Square root and division for the unit axis, CORDIC sine and cosine, and
// the three Rodrigues terms with rounding and saturation.
// ----------------------------------------------------------------------------
module aavr_back #(
  parameter int CORDIC_STAGES = aavr_pkg::DEF_CORDIC_STAGES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  aavr_pkg::aavr_item_t q_item,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [95:0]          m_tdata,
  output logic [1:0]           m_tuser
);

  localparam int CW  = aavr_pkg::COMP_W;
  localparam int RW  = aavr_pkg::R_W;
  localparam int XW  = aavr_pkg::RND_W;
  localparam int UW  = aavr_pkg::U_W;
  localparam int SW  = aavr_pkg::CS_W;
  localparam int ZW  = aavr_pkg::Z_W;
  localparam int OMW = aavr_pkg::UNIT_SHIFT + 3;
  localparam int SUMW = RW + 2;

  // Stage positions along the pipeline
  localparam int ST_SQ  = 0;
  localparam int ST_SUM = 1;
  localparam int ST_RT0 = 2;
  localparam int ST_DV0 = ST_RT0 + aavr_pkg::ROOT_W;
  localparam int ST_U   = ST_DV0 + aavr_pkg::Q_W;
  localparam int ST_MAP = ST_U + 1 + CORDIC_STAGES;
  localparam int ST_K1  = ST_MAP + 1;
  localparam int ST_K2  = ST_K1 + 1;
  localparam int ST_K6  = ST_K2 + 4;
  localparam int ST_OUT = ST_K6 + 1;
  localparam int NST    = ST_OUT + 1;
  localparam int LU     = ST_K2 - ST_U + 1;

  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  logic                        adv;
  logic [NST-1:0]              vld;
  aavr_pkg::aavr_item_t        itm [NST];

  logic [aavr_pkg::SQ_W-1:0]   sq [3];
  logic [aavr_pkg::REM_W-1:0]  rt_rem  [aavr_pkg::ROOT_W+1];
  logic [aavr_pkg::ROOT_W-1:0] rt_root [aavr_pkg::ROOT_W+1];
  logic [aavr_pkg::Q_W-1:0]    dv_rem [aavr_pkg::Q_W][3];
  logic [aavr_pkg::Q_W-1:0]    dv_q   [aavr_pkg::Q_W][3];
  logic [aavr_pkg::ROOT_W-1:0] dv_m   [aavr_pkg::Q_W];

  logic signed [UW-1:0]        u_p [LU][3];
  logic signed [SW-1:0]        cx [CORDIC_STAGES+1];
  logic signed [SW-1:0]        cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0]        cz [CORDIC_STAGES+1];
  logic [1:0]                  cquad [CORDIC_STAGES+1];
  logic signed [CW-1:0]        c_m, s_m;

  logic signed [2*CW-1:0]      pc [6];
  logic signed [2*CW-1:0]      pd [3];
  logic signed [2*CW-1:0]      pt1 [3];
  logic signed [CW-1:0]        k1_c, k1_s, k2_c, k2_s, k3_c, k4_c;
  logic signed [RW-1:0]        cr [3];
  logic signed [RW-1:0]        d;
  logic signed [RW-1:0]        k2_t1r [3], k3_t1r [3], k4_t1r [3], k5_t1r [3], k6_t1r [3];
  logic signed [RW+CW-1:0]     t2 [3];
  logic signed [RW+UW-1:0]     w [3];
  logic signed [RW-1:0]        k4_t2r [3], k5_t2r [3], k6_t2r [3];
  logic signed [RW-1:0]        wr [3];
  logic signed [RW+OMW-1:0]    t3 [3];
  logic signed [RW-1:0]        t3r [3];
  logic signed [OMW-1:0]       omc;

  logic [CW-1:0]               rot_q [3];
  logic                        zero_q;
  logic                        clip_q;

  // The whole pipeline moves when the output register is free or taken.
  assign adv     = !vld[NST-1] || m_tready;
  assign q_ready = adv;

  // Valid flags and the item carried alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm[0] <= q_item;
      for (int k = 1; k < NST; k++) itm[k] <= itm[k-1];
    end
  end

  // Squares of the scaled axis magnitudes, then their sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq[i] <= q_item.nmag[i] * q_item.nmag[i];
      rt_rem[0]  <= aavr_pkg::REM_W'(sq[0]) + aavr_pkg::REM_W'(sq[1])
                    + aavr_pkg::REM_W'(sq[2]);
      rt_root[0] <= '0;
    end
  end

  // Floor square root, one result bit per stage.
  for (genvar k = 0; k < aavr_pkg::ROOT_W; k++) begin : g_sqrt
    localparam int B = aavr_pkg::ROOT_W - 1 - k;
    logic [aavr_pkg::REM_W-1:0] trial;
    assign trial = (aavr_pkg::REM_W'(rt_root[k]) << (B + 1))
                   + (aavr_pkg::REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rt_rem[k] >= trial) begin
          rt_rem[k+1]  <= rt_rem[k] - trial;
          rt_root[k+1] <= rt_root[k] | (aavr_pkg::ROOT_W'(1) << B);
        end else begin
          rt_rem[k+1]  <= rt_rem[k];
          rt_root[k+1] <= rt_root[k];
        end
      end
    end
  end

  // Restoring division of each magnitude times 2^30 by the root.
  for (genvar k = 0; k < aavr_pkg::Q_W; k++) begin : g_div
    localparam int B = aavr_pkg::Q_W - 1 - k;
    logic [aavr_pkg::ROOT_W-1:0] m_in;
    logic [aavr_pkg::Q_W:0]      r2 [3];
    always_comb begin
      if (k == 0) m_in = rt_root[aavr_pkg::ROOT_W];
      else        m_in = dv_m[(k == 0) ? 0 : k-1];
      for (int j = 0; j < 3; j++) begin
        if (k == 0) begin
          r2[j] = {aavr_pkg::Q_W'(itm[ST_DV0-1].nmag[j] >> 1),
                   itm[ST_DV0-1].nmag[j][0]};
        end else begin
          r2[j] = {dv_rem[(k == 0) ? 0 : k-1][j], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_m[k] <= m_in;
        for (int j = 0; j < 3; j++) begin
          if (r2[j] >= (aavr_pkg::Q_W+1)'(m_in)) begin
            dv_rem[k][j] <= aavr_pkg::Q_W'(r2[j] - (aavr_pkg::Q_W+1)'(m_in));
            dv_q[k][j]   <= ((k == 0) ? '0 : dv_q[(k == 0) ? 0 : k-1][j])
                            | (aavr_pkg::Q_W'(1) << B);
          end else begin
            dv_rem[k][j] <= r2[j][aavr_pkg::Q_W-1:0];
            dv_q[k][j]   <= (k == 0) ? '0 : dv_q[(k == 0) ? 0 : k-1][j];
          end
        end
      end
    end
  end

  // Signed unit axis and the CORDIC start values.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        u_p[0][j] <= itm[ST_U-1].neg[j] ? -$signed({1'b0, dv_q[aavr_pkg::Q_W-1][j]})
                                        : $signed({1'b0, dv_q[aavr_pkg::Q_W-1][j]});
      end
      for (int k = 1; k < LU; k++) u_p[k] <= u_p[k-1];
      cx[0]    <= aavr_pkg::CORDIC_GAIN;
      cy[0]    <= '0;
      cz[0]    <= $signed({2'b00, itm[ST_U-1].angle[aavr_pkg::ANGLE_W-3:0],
                           {(aavr_pkg::TURN_W - aavr_pkg::ANGLE_W){1'b0}}});
      cquad[0] <= itm[ST_U-1].angle[aavr_pkg::ANGLE_W-1 -: 2];
    end
  end

  // Rotation-mode CORDIC, one micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [SW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = cx[i] >>> i;
    assign dy = cy[i] >>> i;
    assign at = $signed({2'b00, aavr_pkg::ATAN_TURN[i]});
    always_ff @(posedge clk) begin
      if (adv) begin
        cquad[i+1] <= cquad[i];
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - dy;
          cy[i+1] <= cy[i] + dx;
          cz[i+1] <= cz[i] - at;
        end else begin
          cx[i+1] <= cx[i] + dy;
          cy[i+1] <= cy[i] - dx;
          cz[i+1] <= cz[i] + at;
        end
      end
    end
  end

  // Clamp to the unit range and map by quadrant.
  logic signed [SW-1:0] xcl, ycl;
  always_comb begin
    xcl = cx[CORDIC_STAGES];
    ycl = cy[CORDIC_STAGES];
    if (xcl > (SW'(1) <<< aavr_pkg::UNIT_SHIFT)) xcl = SW'(1) <<< aavr_pkg::UNIT_SHIFT;
    if (xcl < -(SW'(1) <<< aavr_pkg::UNIT_SHIFT)) xcl = -(SW'(1) <<< aavr_pkg::UNIT_SHIFT);
    if (ycl > (SW'(1) <<< aavr_pkg::UNIT_SHIFT)) ycl = SW'(1) <<< aavr_pkg::UNIT_SHIFT;
    if (ycl < -(SW'(1) <<< aavr_pkg::UNIT_SHIFT)) ycl = -(SW'(1) <<< aavr_pkg::UNIT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (cquad[CORDIC_STAGES])
        2'd0: begin
          c_m <= xcl[CW-1:0];
          s_m <= ycl[CW-1:0];
        end
        2'd1: begin
          c_m <= -ycl[CW-1:0];
          s_m <= xcl[CW-1:0];
        end
        2'd2: begin
          c_m <= -xcl[CW-1:0];
          s_m <= -ycl[CW-1:0];
        end
        default: begin
          c_m <= ycl[CW-1:0];
          s_m <= -xcl[CW-1:0];
        end
      endcase
    end
  end

  // Cross, dot and cosine products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pc[2*i]   <= u_p[ST_MAP-ST_U][NXT1[i]] * $signed(itm[ST_MAP].vec[NXT2[i]]);
        pc[2*i+1] <= u_p[ST_MAP-ST_U][NXT2[i]] * $signed(itm[ST_MAP].vec[NXT1[i]]);
        pd[i]     <= u_p[ST_MAP-ST_U][i] * $signed(itm[ST_MAP].vec[i]);
        pt1[i]    <= $signed(itm[ST_MAP].vec[i]) * c_m;
      end
      k1_c <= c_m;
      k1_s <= s_m;
    end
  end

  // Round the cross, dot and cosine terms back to the vector format.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cr[i]     <= aavr_pkg::rnd30(XW'(pc[2*i]) - XW'(pc[2*i+1]));
        k2_t1r[i] <= aavr_pkg::rnd30(XW'(pt1[i]));
      end
      d    <= aavr_pkg::rnd30(XW'(pd[0]) + XW'(pd[1]) + XW'(pd[2]));
      k2_c <= k1_c;
      k2_s <= k1_s;
    end
  end

  // Sine term and axis times the projection.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t2[i]     <= cr[i] * k2_s;
        w[i]      <= u_p[LU-1][i] * d;
        k3_t1r[i] <= k2_t1r[i];
      end
      k3_c <= k2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        k4_t2r[i] <= aavr_pkg::rnd30(XW'(t2[i]));
        wr[i]     <= aavr_pkg::rnd30(XW'(w[i]));
        k4_t1r[i] <= k3_t1r[i];
      end
      k4_c <= k3_c;
    end
  end

  // One minus cosine term.
  assign omc = (OMW'(1) <<< aavr_pkg::UNIT_SHIFT) - OMW'(k4_c);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t3[i]     <= wr[i] * omc;
        k5_t1r[i] <= k4_t1r[i];
        k5_t2r[i] <= k4_t2r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t3r[i]    <= aavr_pkg::rnd30(XW'(t3[i]));
        k6_t1r[i] <= k5_t1r[i];
        k6_t2r[i] <= k5_t2r[i];
      end
    end
  end

  // Sum, saturate, and pass the vector through for a zero axis.
  logic signed [SUMW-1:0] rsum [3];
  logic [2:0]             sat;
  logic [CW-1:0]          rsat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = SUMW'(k6_t1r[i]) + SUMW'(k6_t2r[i]) + SUMW'(t3r[i]);
      sat[i]  = 1'b1;
      if (rsum[i] > SUMW'((64'sd1 <<< (CW - 1)) - 1)) begin
        rsat[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (rsum[i] < -(SUMW'(1) <<< (CW - 1))) begin
        rsat[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        rsat[i] = rsum[i][CW-1:0];
        sat[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_q <= itm[ST_K6].zero;
      clip_q <= !itm[ST_K6].zero && (sat != '0);
      for (int i = 0; i < 3; i++) begin
        rot_q[i] <= itm[ST_K6].zero ? itm[ST_K6].vec[i] : rsat[i];
      end
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {rot_q[2], rot_q[1], rot_q[0]};
  assign m_tuser  = {clip_q, zero_q};

  // A zero axis never reports saturation.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && zero_q) |-> !clip_q)
    else $error("zero axis reported as clipped");

  // A stalled pipeline keeps its occupancy.
  assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("pipeline occupancy changed while stalled");

  // A transaction taken from the queue lands in the first stage.
  assert property (@(posedge clk) disable iff (rst) (q_valid && adv) |=> vld[0])
    else $error("queue item lost on entry");

endmodule

### design/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation: rotates a vector about an axis by an angle
// Rodrigues' formula with square-root normalisation and CORDIC sine/cosine.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not stalled
// and returns one result per transaction, in order. Its pipeline holds the
// bit-per-stage square root (31 stages), the bit-per-stage divider for
// the unit axis (31 stages) and the CORDIC stages. Input data carries the
// vector, the axis (any nonzero length) and the angle in 2^16 units per turn;
// a zero axis returns the vector unchanged with axis_was_zero set, and a
// component outside the signed 32-bit range saturates with clipped set.
module axis_angle_vector_rotation #(
  parameter int CORDIC_STAGES = aavr_pkg::DEF_CORDIC_STAGES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_x, rot_y, rot_z
  output logic [95:0]  m_axis_tdata,
  // axis_was_zero, clipped
  output logic [1:0]   m_axis_tuser
);

  logic                 fq_valid, fq_ready;
  aavr_pkg::aavr_item_t fq_item;
  logic                 qb_valid, qb_ready;
  aavr_pkg::aavr_item_t qb_item;

  aavr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  aavr_queue #(
    .DEPTH (aavr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  aavr_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_item   (qb_item),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule

### bench/axis_angle_vector_rotation_test.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_test: self-checking bench for the rotation block
// Drives directed and random vector/axis/angle transactions through the slave
// stream, predicts each rotated vector with a bit-exact model of the
// normalisation, CORDIC and Rodrigues arithmetic, and checks the master stream
// in order, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module axis_angle_vector_rotation_test;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_PER_PHASE = 250;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  // One input transaction, with an optional expectation typed in by hand.
  typedef struct {
    logic signed [31:0] vec [3];
    logic signed [31:0] axis [3];
    logic [15:0]        angle;
    bit                 fixed;
    logic signed [31:0] fixed_rot [3];
    bit                 fixed_zero;
    bit                 fixed_clip;
    int                 phase;
  } rot_item_t;

  typedef struct {
    logic signed [31:0] rot [3];
    bit                 zero;
    bit                 clip;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  rot_item_t   stim_q [$];
  rot_result_t rotated_q [$];
  rot_item_t   cur_item;
  int          cur_phase = 0;
  int          fails = 0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  axis_angle_vector_rotation u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Round half up out of Q2.30: add one half, then shift right with floor.
  function automatic longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Bit-exact prediction of one rotated vector.
  function automatic rot_result_t rotate_vector(rot_item_t it);
    rot_result_t res;
    longint v [3], ax [3], unit [3], cr [3];
    longint unsigned mag [3], mx, sumsq, root, bitv, rem;
    longint x, y, z, dx, dy, c, s, d, omc, r, w, sum;
    logic [31:0] turn;
    int len;
    for (int i = 0; i < 3; i++) begin
      v[i] = it.vec[i];
      ax[i] = it.axis[i];
    end
    res.zero = 0;
    res.clip = 0;
    if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) begin
      for (int i = 0; i < 3; i++) res.rot[i] = it.vec[i];
      res.zero = 1;
      return res;
    end
    // Normalise the largest magnitude into [2^29, 2^30).
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (ax[i] < 0) ? longint'(-ax[i]) : longint'(ax[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    len = 0;
    while (len < 63 && (mx >> len) != 0) len++;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) mag[i] = mag[i] >> (len - 30);
      else mag[i] = mag[i] << (30 - len);
      sumsq += mag[i] * mag[i];
    end
    // Floor square root, one result bit per pass.
    root = 0;
    rem = sumsq;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root == 0) root = 1;
    for (int i = 0; i < 3; i++) begin
      unit[i] = longint'((mag[i] << 30) / root);
      if (ax[i] < 0) unit[i] = -unit[i];
    end
    // CORDIC over the low 30 bits of the turn, quadrant applied afterwards.
    turn = {it.angle, 16'h0000};
    z = longint'(turn[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(aavr_pkg::ATAN_TURN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(aavr_pkg::ATAN_TURN[i]);
      end
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (y > ONE_Q30) y = ONE_Q30;
    if (y < -ONE_Q30) y = -ONE_Q30;
    case (turn[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    // Rodrigues terms.
    cr[0] = round_q30(unit[1] * v[2] - unit[2] * v[1]);
    cr[1] = round_q30(unit[2] * v[0] - unit[0] * v[2]);
    cr[2] = round_q30(unit[0] * v[1] - unit[1] * v[0]);
    d = round_q30(unit[0] * v[0] + unit[1] * v[1] + unit[2] * v[2]);
    omc = ONE_Q30 - c;
    for (int i = 0; i < 3; i++) begin
      w = round_q30(unit[i] * d);
      sum = round_q30(v[i] * c) + round_q30(cr[i] * s) + round_q30(w * omc);
      r = sum;
      if (r > 64'sd2147483647) begin r = 64'sd2147483647; res.clip = 1; end
      if (r < -64'sd2147483648) begin r = -64'sd2147483648; res.clip = 1; end
      res.rot[i] = r[31:0];
    end
    return res;
  endfunction

  // Directed row; a zero-axis row carries its expectation.
  function automatic rot_item_t make_row(longint vx, longint vy, longint vz,
                                         longint ax, longint ay, longint az,
                                         int ang);
    rot_item_t it;
    it.vec[0] = vx[31:0]; it.vec[1] = vy[31:0]; it.vec[2] = vz[31:0];
    it.axis[0] = ax[31:0]; it.axis[1] = ay[31:0]; it.axis[2] = az[31:0];
    it.angle = ang[15:0];
    it.phase = 0;
    it.fixed = (ax == 0 && ay == 0 && az == 0);
    it.fixed_rot = it.vec;
    it.fixed_zero = 1;
    it.fixed_clip = 0;
    return it;
  endfunction

  // Random component: mostly full range, sometimes small, rarely zero.
  function automatic logic [31:0] rand_comp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 9) return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    return '0;
  endfunction

  function automatic rot_item_t make_random(int phase);
    rot_item_t it;
    for (int i = 0; i < 3; i++) begin
      it.vec[i] = rand_comp();
      it.axis[i] = rand_comp();
    end
    if ($urandom_range(0, 19) == 0) begin
      for (int i = 0; i < 3; i++) it.axis[i] = '0;
    end
    it.angle = 16'($urandom);
    it.fixed = 0;
    it.phase = phase;
    return it;
  endfunction

  // Sender: offers the next transaction whenever the slot is free, except for random gaps in phases 1 and 3.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_item.fixed) begin
          rot_result_t fx;
          fx.rot = cur_item.fixed_rot;
          fx.zero = cur_item.fixed_zero;
          fx.clip = cur_item.fixed_clip;
          rotated_q.push_back(fx);
        end else begin
          rotated_q.push_back(rotate_vector(cur_item));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_q.size() > 0 &&
            !((cur_phase == 1 && $urandom_range(0, 99) < 47) ||
              (cur_phase == 3 && $urandom_range(0, 99) < 27))) begin
          cur_item = stim_q.pop_front();
          cur_phase <= cur_item.phase;
          s_axis_tdata <= {cur_item.angle, cur_item.axis[2], cur_item.axis[1],
                           cur_item.axis[0], cur_item.vec[2], cur_item.vec[1],
                           cur_item.vec[0]};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls by phase and checks every result transaction in order.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !((cur_phase == 2 && $urandom_range(0, 99) < 47) ||
                         (cur_phase == 3 && $urandom_range(0, 99) < 27));
      if (m_axis_tvalid && m_axis_tready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h / %b",
                   $time, m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          rot_result_t exp_res;
          exp_res = rotated_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (m_axis_tdata[32*i +: 32] !== exp_res.rot[i]) begin
              $display("%0t: rot component %0d expected %h actual %h",
                       $time, i, exp_res.rot[i], m_axis_tdata[32*i +: 32]);
              fails++;
            end
          end
          if (m_axis_tuser[0] !== exp_res.zero) begin
            $display("%0t: axis_was_zero expected %b actual %b",
                     $time, exp_res.zero, m_axis_tuser[0]);
            fails++;
          end
          if (m_axis_tuser[1] !== exp_res.clip) begin
            $display("%0t: clipped expected %b actual %b",
                     $time, exp_res.clip, m_axis_tuser[1]);
            fails++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rot_item_t directed [];
    directed = new [18];
    // Zero axis passes the vector through, extremes included.
    directed[0]  = make_row(64'sh7FFFFFFF, -64'sh80000000, 0, 0, 0, 0, 0);
    directed[1]  = make_row(-64'sh80000000, 64'sh7FFFFFFF, -1, 0, 0, 0, 65535);
    directed[2]  = make_row(65536, 2, 3, 0, 0, 0, 16384);
    // Quarter-turn angles about the z axis, then other angles about x and y.
    directed[3]  = make_row(65536, 0, 0, 0, 0, 65536, 0);
    directed[4]  = make_row(65536, 0, 0, 0, 0, 65536, 16384);
    directed[5]  = make_row(65536, 0, 0, 0, 0, 65536, 32768);
    directed[6]  = make_row(65536, 0, 0, 0, 0, 65536, 49152);
    directed[7]  = make_row(0, 65536, 0, 65536, 0, 0, 65535);
    directed[8]  = make_row(0, 0, 65536, 0, 65536, 0, 8192);
    // Axis extremes: tiny, most negative and largest lengths.
    directed[9]  = make_row(123456, -654321, 777, 1, 0, 0, 12345);
    directed[10] = make_row(123456, -654321, 777, -64'sh80000000, -64'sh80000000,
                            -64'sh80000000, 40000);
    directed[11] = make_row(-5, 99999, 31, 64'sh7FFFFFFF, 64'sh7FFFFFFF, 1, 1);
    directed[12] = make_row(1, 1, 1, -1, -1, -1, 21845);
    // Saturation: extreme vectors turned so a component leaves the range, then a small vector about an extreme axis.
    directed[13] = make_row(-64'sh80000000, 0, 0, 0, 0, 65536, 32768);
    directed[14] = make_row(64'sh7FFFFFFF, 64'sh7FFFFFFF, 0, 0, 0, 1, 8192);
    directed[15] = make_row(-64'sh80000000, -64'sh80000000, -64'sh80000000,
                            1, 1, 0, 57344);
    directed[16] = make_row(64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF,
                            3, -7, 11, 30000);
    directed[17] = make_row(-1, -1, -1, 64'sh7FFFFFFF, -64'sh80000000, 0, 65535);
    foreach (directed[i]) stim_q.push_back(directed[i]);
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) stim_q.push_back(make_random(p));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() > 0 || s_axis_tvalid || rotated_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
